// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// Textured wall column scaler package
// Shared transaction types, function codes, register indexes and constants.
// ----------------------------------------------------------------------------
package tws_pkg;

	// Fraction bits of the row position and the row step.
	localparam int FRAC_W = 16;
	// Width of the channel reciprocal, which reaches 2^16 for a divisor of one.
	localparam int RECIP_W = 17;
	// Width of one color channel.
	localparam int CH_W = 8;

	// Function codes of an input transaction.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_BEGIN = 2'd1;
	localparam logic [1:0] FUNC_ROW   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_SCREEN_ROWS = 2'd2;

	// Configuration reset values.
	localparam logic [6:0]  TEX_WIDTH_RST   = 7'd64;
	localparam logic [6:0]  TEX_HEIGHT_RST  = 7'd64;
	localparam logic [11:0] SCREEN_ROWS_RST = 12'd480;

	// Alpha of an opaque shaded pixel.
	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// One input transaction.
	typedef struct packed {
		logic [1:0]         func;
		logic [11:0]        texel_address;
		logic [31:0]        texel_value;
		logic signed [15:0] start_row;
		logic signed [15:0] end_row;
		logic [5:0]         texture_column;
		logic [11:0]        screen_column;
		logic               shaded;
		logic [7:0]         lum_mod;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [10:0] row;
		logic [11:0] column;
		logic [31:0] color;
		logic        write_enable;
		logic        last_row;
	} result_t;

	// Per-pixel information that travels beside the texture read.
	typedef struct packed {
		logic [10:0]        row;
		logic [11:0]        column;
		logic               shaded;
		logic               last_row;
		logic [RECIP_W-1:0] recip;
	} pix_t;

endpackage

// ===== rtl/textured_wall_column_scaler_top.sv =====
// ----------------------------------------------------------------------------
// Textured wall column scaler
// Texture store, strip setup sequencer and per-row texel sampling.
// ----------------------------------------------------------------------------
// A row transaction gives its pixel on strobe through the memory read, stage-two
// and output registers. Writes and row transactions are taken every cycle while
// not busy; results are never held off. A visible begin holds busy while the
// shared bit-serial divider forms the row step and the channel reciprocal.
// Reset clears the sequencer, the pipeline valids and the configuration;
// the texture store is not cleared and holds nothing defined until written.
module textured_wall_column_scaler_top import tws_pkg::*; #(
	parameter int MAX_TEXTURE_SIDE = 64,
	parameter int MAX_SCREEN_ROWS  = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output logic        strobe,
	output result_t     result
);

	localparam int SIDE_W   = $clog2(MAX_TEXTURE_SIDE + 1);
	localparam int NUM_W    = SIDE_W + FRAC_W;
	localparam int DEPTH    = MAX_TEXTURE_SIDE * MAX_TEXTURE_SIDE;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int ADV_W    = NUM_W + 16;
	localparam int MOD_SH   = 24;
	localparam int MOD_MUL  = (2 ** MOD_SH) / DEPTH;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_STEP  = 3'd1;
	localparam logic [2:0] ST_RECIP = 3'd2;
	localparam logic [2:0] ST_ADV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]         state_q;
	logic               active_q;
	logic [6:0]         width_q;
	logic [6:0]         height_q;
	logic [11:0]        rows_q;

	logic [31:0]        pos_q;
	logic [NUM_W-1:0]   step_q;
	logic [11:0]        cur_q;
	logic [11:0]        stop_q;
	logic [11:0]        first_q;
	logic [5:0]         col_q;
	logic [11:0]        scol_q;
	logic               shaded_q;
	logic [7:0]         div_q;
	logic [RECIP_W-1:0] recip_q;
	logic [15:0]        neg_q;
	logic               adv_en_q;
	logic [ADV_W-1:0]   adv_q;

	logic               accept;
	logic               do_write;
	logic               do_begin;
	logic               do_row;

	logic [8:0]         w_ext;
	logic [8:0]         h_ext;
	logic [SIDE_W-1:0]  h_c;
	logic [12:0]        rows_c;

	logic signed [16:0] start17;
	logic signed [16:0] end17;
	logic signed [16:0] len17;
	logic signed [16:0] nstart17;
	logic signed [16:0] first17;
	logic signed [16:0] stop17;
	logic signed [16:0] rows17;
	logic               visible;

	logic [8:0]         hm1;
	logic [8:0]         wm1;
	logic [8:0]         trow_c;
	logic [8:0]         tcol_c;
	logic [17:0]        raddr_full;
	logic [ADDR_W-1:0]  raddr;
	logic               last;
	logic [32:0]        pos_sum;

	logic [31:0]        mod_prod;
	logic [7:0]         mod_q;
	logic [16:0]        mod_r;
	logic [16:0]        mod_fix;
	logic [ADDR_W-1:0]  waddr;

	logic               div_go;
	logic               div_done;
	logic [NUM_W-1:0]   div_numer;
	logic [15:0]        div_denom;
	logic [NUM_W-1:0]   div_quot;
	logic [16:0]        recip_numer;

	logic [31:0]        texel;
	pix_t               pix;

	// Transaction decode.
	assign accept   = start && !busy;
	assign do_write = accept && cmd.func == FUNC_WRITE;
	assign do_begin = accept && cmd.func == FUNC_BEGIN;
	assign do_row   = accept && cmd.func == FUNC_ROW && active_q;
	assign busy     = state_q != ST_IDLE;

	// Clamp the configuration to the supported ranges.
	always_comb begin
		w_ext = {2'b0, width_q};
		if (w_ext == 9'd0) begin
			w_ext = 9'd1;
		end else if (w_ext > 9'(MAX_TEXTURE_SIDE)) begin
			w_ext = 9'(MAX_TEXTURE_SIDE);
		end
		h_ext = {2'b0, height_q};
		if (h_ext == 9'd0) begin
			h_ext = 9'd1;
		end else if (h_ext > 9'(MAX_TEXTURE_SIDE)) begin
			h_ext = 9'(MAX_TEXTURE_SIDE);
		end
		h_c    = h_ext[SIDE_W-1:0];
		rows_c = {1'b0, rows_q};
		if (rows_c > 13'(MAX_SCREEN_ROWS)) begin
			rows_c = 13'(MAX_SCREEN_ROWS);
		end
	end

	// Strip geometry of a begin transaction.
	always_comb begin
		start17  = 17'(cmd.start_row);
		end17    = 17'(cmd.end_row);
		len17    = end17 - start17;
		nstart17 = -start17;
		rows17   = $signed({4'b0, rows_c});
		first17  = start17[16] ? 17'sd0 : start17;
		stop17   = (end17 < rows17) ? end17 : rows17;
		visible  = (len17 > 17'sd0) && (first17 < stop17);
	end

	// Texture address of the current row, saturated in both directions.
	always_comb begin
		hm1        = h_ext - 9'd1;
		wm1        = w_ext - 9'd1;
		trow_c     = (pos_q[31:16] > {7'b0, hm1}) ? hm1 : pos_q[24:16];
		tcol_c     = ({3'b0, col_q} > wm1) ? wm1 : {3'b0, col_q};
		raddr_full = 18'(trow_c) * 18'(w_ext) + 18'(tcol_c);
		raddr      = raddr_full[ADDR_W-1:0];
		last       = ({1'b0, cur_q} + 13'd1) == {1'b0, stop_q};
		pos_sum    = {1'b0, pos_q} + 33'(step_q);
	end

	// Texel write address reduced modulo the store depth.
	always_comb begin
		mod_prod = 32'(cmd.texel_address) * 32'(MOD_MUL);
		mod_q    = mod_prod[31:MOD_SH];
		mod_r    = 17'(cmd.texel_address) - 17'(mod_q) * 17'(DEPTH);
		mod_fix  = (mod_r >= 17'(DEPTH)) ? mod_r - 17'(DEPTH) : mod_r;
		waddr    = mod_fix[ADDR_W-1:0];
	end

	// Divider operands: row step first, then the channel reciprocal.
	always_comb begin
		recip_numer = 17'(2 ** FRAC_W) + 17'(div_q) - 17'd1;
		div_go      = (do_begin && visible) || (state_q == ST_STEP && div_done);
		if (state_q == ST_IDLE) begin
			div_numer = {h_c, {FRAC_W{1'b0}}};
			div_denom = len17[15:0];
		end else begin
			div_numer = {{(NUM_W - 17){1'b0}}, recip_numer};
			div_denom = {8'b0, div_q};
		end
	end

	tws_divider #(
		.NUM_W(NUM_W),
		.DEN_W(16)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.numer (div_numer),
		.denom (div_denom),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= TEX_WIDTH_RST;
			height_q <= TEX_HEIGHT_RST;
			rows_q   <= SCREEN_ROWS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TEX_WIDTH: begin
					width_q <= cfg_data[6:0];
				end
				REG_TEX_HEIGHT: begin
					height_q <= cfg_data[6:0];
				end
				REG_SCREEN_ROWS: begin
					rows_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Strip setup sequencer and strip activity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_begin) begin
						active_q <= 1'b0;
						if (visible) begin
							state_q <= ST_STEP;
						end
					end else if (do_row && last) begin
						active_q <= 1'b0;
					end
				end
				ST_STEP: begin
					if (div_done) begin
						state_q <= ST_RECIP;
					end
				end
				ST_RECIP: begin
					if (div_done) begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					active_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Strip datapath.
	always_ff @(posedge clk) begin
		if (do_begin) begin
			col_q    <= cmd.texture_column;
			scol_q   <= cmd.screen_column;
			shaded_q <= cmd.shaded;
			div_q    <= (cmd.lum_mod == 8'd0) ? 8'd1 : cmd.lum_mod;
			first_q  <= first17[11:0];
			stop_q   <= stop17[11:0];
			neg_q    <= nstart17[15:0];
			adv_en_q <= start17[16];
		end
		if (state_q == ST_STEP && div_done) begin
			step_q <= div_quot;
		end
		if (state_q == ST_RECIP && div_done) begin
			recip_q <= div_quot[RECIP_W-1:0];
		end
		if (state_q == ST_ADV) begin
			adv_q <= ADV_W'(step_q) * ADV_W'(neg_q);
		end
		if (state_q == ST_FIN) begin
			cur_q <= first_q;
			if (!adv_en_q) begin
				pos_q <= 32'd0;
			end else if (|adv_q[ADV_W-1:32]) begin
				pos_q <= '1;
			end else begin
				pos_q <= adv_q[31:0];
			end
		end
		if (do_row) begin
			cur_q <= cur_q + 12'd1;
			pos_q <= pos_sum[32] ? '1 : pos_sum[31:0];
		end
	end

	tws_texmem #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_texmem (
		.clk  (clk),
		.we   (do_write),
		.waddr(waddr),
		.wdata(cmd.texel_value),
		.raddr(raddr),
		.rdata(texel)
	);

	// Pixel information that follows the texture read.
	always_comb begin
		pix.row      = cur_q[10:0];
		pix.column   = scol_q;
		pix.shaded   = shaded_q;
		pix.last_row = last;
		pix.recip    = recip_q;
	end

	tws_shade u_shade (
		.clk   (clk),
		.arst_n(arst_n),
		.issue (do_row),
		.pix   (pix),
		.texel (texel),
		.strobe(strobe),
		.result(result)
	);

`ifndef SYNTHESIS
	// Every pixel comes from a row transaction taken earlier.
	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy && cmd.func == FUNC_ROW, 3))
		else $error("pixel strobe without a row transaction");

	// The divider only finishes while the sequencer waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_STEP || state_q == ST_RECIP))
		else $error("divider finished outside of strip setup");

	// An active strip always has rows left to draw.
	a_rows_left: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cur_q < stop_q))
		else $error("active strip past its stop row");

	// No strip is live while a new one is being set up.
	a_setup_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !active_q)
		else $error("strip active during setup");
`endif

endmodule

// ===== rtl/tws_texmem.sv =====
// ----------------------------------------------------------------------------
// Texture memory
// Single-port-write, single-port-read texel store with a registered read.
// ----------------------------------------------------------------------------
module tws_texmem #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tws_divider.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tws_divider #(
	parameter int NUM_W = 23,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Bring down the next numerator bit and test against the divisor.
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient datapath.
	always_ff @(posedge clk) begin
		if (go) begin
			num_q  <= numer;
			den_q  <= denom;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/tws_shade.sv =====
// ----------------------------------------------------------------------------
// Pixel shading pipeline
// Takes the texel read, scales the channels of a shaded pixel by the divisor
// reciprocal and registers one result transaction per row.
// ----------------------------------------------------------------------------
module tws_shade import tws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        issue,
	input  pix_t        pix,
	input  logic [31:0] texel,
	output logic        strobe,
	output result_t     result
);

	localparam int PROD_W = CH_W + RECIP_W;

	logic              valid_s1;
	pix_t              pix_s1;
	logic              valid_s2;
	pix_t              pix_s2;
	logic [31:0]       texel_s2;
	logic [PROD_W-1:0] prod_r_s2;
	logic [PROD_W-1:0] prod_g_s2;
	logic [PROD_W-1:0] prod_b_s2;
	logic              strobe_q;
	result_t           result_q;
	result_t           result_d;
	logic              opaque;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2;
		end
	end

	// Stage one waits for the memory; stage two multiplies by the reciprocal.
	always_ff @(posedge clk) begin
		pix_s1    <= pix;
		pix_s2    <= pix_s1;
		texel_s2  <= texel;
		prod_r_s2 <= PROD_W'(texel[23:16]) * PROD_W'(pix_s1.recip);
		prod_g_s2 <= PROD_W'(texel[15:8]) * PROD_W'(pix_s1.recip);
		prod_b_s2 <= PROD_W'(texel[7:0]) * PROD_W'(pix_s1.recip);
	end

	// Pack the pixel.
	always_comb begin
		opaque                = texel_s2 != 32'd0;
		result_d.row          = pix_s2.row;
		result_d.column       = pix_s2.column;
		result_d.last_row     = pix_s2.last_row;
		if (pix_s2.shaded) begin
			result_d.color = {opaque ? ALPHA_OPAQUE : 8'd0,
				prod_r_s2[FRAC_W+CH_W-1:FRAC_W],
				prod_g_s2[FRAC_W+CH_W-1:FRAC_W],
				prod_b_s2[FRAC_W+CH_W-1:FRAC_W]};
			result_d.write_enable = 1'b1;
		end else begin
			result_d.color        = texel_s2;
			result_d.write_enable = opaque;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Textured wall column scaler testbench
// Loads the texture store, then drives texel writes, strip begins and row
// transactions under several register settings. A scoreboard predicts every
// pixel and compares each strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	import tws_pkg::*;

	localparam int STORE_DEPTH  = 4096;
	// Texels loaded at the start; every register setting keeps its reads below this.
	localparam int FILL_DEPTH   = 512;
	localparam int SIDE_MAX     = 64;
	localparam int ROWS_MAX     = 2048;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam int REPORT_LINES = 20;
	// A begin holds busy while the divider forms the row step and the reciprocal; this leaves a wide margin.
	localparam int STALL_LIMIT  = 1000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Pixel predictor and store of expected pixels.
	class strip_scoreboard;
		bit [31:0] texels [STORE_DEPTH];
		bit [31:0] position;
		bit [31:0] step;
		bit [11:0] row_now;
		bit [11:0] row_stop;
		bit [5:0]  strip_tcol;
		bit [11:0] strip_scol;
		bit        strip_shaded;
		bit [7:0]  strip_div;
		bit        strip_on;
		bit [6:0]  tex_w;
		bit [6:0]  tex_h;
		bit [11:0] scr_rows;
		result_t   expected_pixels [$];
		int        errors;

		function new();
			position = '0;
			step = '0;
			row_now = '0;
			row_stop = '0;
			strip_tcol = '0;
			strip_scol = '0;
			strip_shaded = 1'b0;
			strip_div = 8'd1;
			strip_on = 1'b0;
			tex_w = TEX_WIDTH_RST;
			tex_h = TEX_HEIGHT_RST;
			scr_rows = SCREEN_ROWS_RST;
			errors = 0;
		endfunction

		function int unsigned clamp_side(bit [6:0] v);
			if (v < 1) return 1;
			if (v > SIDE_MAX) return SIDE_MAX;
			return v;
		endfunction

		function int screen_limit();
			return (scr_rows > ROWS_MAX) ? ROWS_MAX : int'(scr_rows);
		endfunction

		function bit pending();
			return expected_pixels.size() != 0;
		endfunction

		function void write_register(logic [1:0] index, logic [11:0] data);
			case (index)
				REG_TEX_WIDTH:   tex_w = data[6:0];
				REG_TEX_HEIGHT:  tex_h = data[6:0];
				REG_SCREEN_ROWS: scr_rows = data;
				default: ;
			endcase
		endfunction

		// Update the state for one accepted transaction and queue its pixel, if any.
		function void note_command(cmd_t c);
			int s, e, len, rows, first, stop;
			longint unsigned adv;
			bit [32:0] sum;
			int unsigned w, h, trow, tcol;
			bit [31:0] texel;
			bit [7:0] alpha;
			result_t p;
			case (c.func)
				FUNC_WRITE: texels[c.texel_address] = c.texel_value;
				FUNC_BEGIN: begin
					s = c.start_row;
					e = c.end_row;
					len = e - s;
					rows = screen_limit();
					strip_tcol = c.texture_column;
					strip_scol = c.screen_column;
					strip_shaded = c.shaded;
					strip_div = (c.lum_mod == 0) ? 8'd1 : c.lum_mod;
					strip_on = 1'b0;
					position = '0;
					step = '0;
					if (len > 0) begin
						step = (clamp_side(tex_h) << FRAC_W) / len;
						first = s;
						// A strip that starts above the screen skips its hidden rows.
						if (s < 0) begin
							adv = 64'(step) * 64'(-s);
							position = (adv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : adv[31:0];
							first = 0;
						end
						stop = (e < rows) ? e : rows;
						if (first < stop) begin
							row_now = 12'(first);
							row_stop = 12'(stop);
							strip_on = 1'b1;
						end
					end
				end
				FUNC_ROW: if (strip_on) begin
					w = clamp_side(tex_w);
					h = clamp_side(tex_h);
					trow = position >> FRAC_W;
					if (trow > h - 1) trow = h - 1;
					tcol = strip_tcol;
					if (tcol > w - 1) tcol = w - 1;
					texel = texels[(trow * w + tcol) % STORE_DEPTH];
					if (strip_shaded) begin
						alpha = (texel != 0) ? ALPHA_OPAQUE : 8'h00;
						p.color = {alpha, texel[23:16] / strip_div,
							texel[15:8] / strip_div, texel[7:0] / strip_div};
						p.write_enable = 1'b1;
					end else begin
						p.color = texel;
						p.write_enable = (texel != 0);
					end
					p.row = row_now[10:0];
					p.column = strip_scol;
					p.last_row = (row_now + 12'd1 == row_stop);
					expected_pixels.push_back(p);
					// The position saturates rather than wrapping.
					sum = {1'b0, position} + step;
					position = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					row_now = row_now + 12'd1;
					if (row_now >= row_stop) strip_on = 1'b0;
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= REPORT_LINES) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Compare one strobed pixel with the oldest expected one.
		task check_pixel(result_t got);
			result_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected pixel at row %0d column %0d",
					got.row, got.column));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.row !== want.row)
				report($sformatf("row %0d, expected %0d", got.row, want.row));
			if (got.column !== want.column)
				report($sformatf("column %0d, expected %0d at row %0d",
					got.column, want.column, want.row));
			if (got.color !== want.color)
				report($sformatf("color %h, expected %h at row %0d",
					got.color, want.color, want.row));
			if (got.write_enable !== want.write_enable)
				report($sformatf("write_enable %b, expected %b at row %0d",
					got.write_enable, want.write_enable, want.row));
			if (got.last_row !== want.last_row)
				report($sformatf("last_row %b, expected %b at row %0d",
					got.last_row, want.last_row, want.row));
		endtask

		task check_drained();
			if (expected_pixels.size() != 0)
				report($sformatf("%0d pixels never arrived", expected_pixels.size()));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        strobe;
	result_t     result;

	strip_scoreboard sb;
	bit idling_on = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;

	textured_wall_column_scaler_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.result    (result)
	);

	always #2 clk = ~clk;

	// Check strobed pixels, note accepted transactions and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1) sb.check_pixel(result);
			if (start && busy === 1'b0) sb.note_command(cmd);
			if (strobe === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic cmd_t random_cmd(logic [1:0] f);
		cmd_t c;
		c.func = f;
		c.texel_address = 12'($urandom);
		c.texel_value = $urandom;
		c.start_row = 16'($urandom);
		c.end_row = 16'($urandom);
		c.texture_column = 6'($urandom);
		c.screen_column = 12'($urandom);
		c.shaded = 1'($urandom);
		c.lum_mod = 8'($urandom);
		return c;
	endfunction

	// Texel values with plenty of transparent and corner cases.
	function automatic logic [31:0] texel_pattern();
		case ($urandom_range(0, 7))
			0, 1: return 32'h0;
			2: return 32'hFFFF_FFFF;
			3: return {8'($urandom), 24'h0};
			default: return $urandom;
		endcase
	endfunction

	// Present one transaction and hold it until it is accepted.
	task automatic send(cmd_t c);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
	endtask

	task automatic send_write(logic [11:0] addr, logic [31:0] value);
		cmd_t c;
		c = random_cmd(FUNC_WRITE);
		c.texel_address = addr;
		c.texel_value = value;
		send(c);
	endtask

	task automatic send_begin(int s, int e, int tcol, int scol, bit shd, int lum);
		cmd_t c;
		c = random_cmd(FUNC_BEGIN);
		c.start_row = 16'(s);
		c.end_row = 16'(e);
		c.texture_column = 6'(tcol);
		c.screen_column = 12'(scol);
		c.shaded = shd;
		c.lum_mod = 8'(lum);
		send(c);
	endtask

	task automatic send_row();
		send(random_cmd(FUNC_ROW));
	endtask

	task automatic send_noise();
		send(random_cmd(FUNC_UNUSED));
	endtask

	// Let every transaction drain before touching the registers or finishing.
	task automatic wait_idle();
		start <= 1'b0;
		repeat (4) @(posedge clk);
		while (busy !== 1'b0 || sb.pending()) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all three registers; unused high bits of the side registers are random.
	task automatic program_registers(bit [6:0] w, bit [6:0] h, bit [11:0] rows);
		logic [11:0] dw, dh;
		dw = {5'($urandom), w};
		dh = {5'($urandom), h};
		cfg_write <= 1'b1;
		cfg_index <= REG_TEX_WIDTH;
		cfg_data <= dw;
		sb.write_register(REG_TEX_WIDTH, dw);
		@(posedge clk);
		cfg_index <= REG_TEX_HEIGHT;
		cfg_data <= dh;
		sb.write_register(REG_TEX_HEIGHT, dh);
		@(posedge clk);
		cfg_index <= REG_SCREEN_ROWS;
		cfg_data <= rows;
		sb.write_register(REG_SCREEN_ROWS, rows);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// One strip with random content, followed by row transactions and some noise.
	task automatic random_strip();
		int rows, s, e, n;
		cmd_t c;
		rows = sb.screen_limit();
		c = random_cmd(FUNC_BEGIN);
		s = int'($urandom_range(0, 80)) - 40;
		e = s + int'($urandom_range(1, 40));
		case ($urandom_range(0, 9))
			6: begin
				s = c.start_row;
				e = c.end_row;
			end
			7: e = s - int'($urandom_range(0, 5));
			8, 9: begin
				s = rows - int'($urandom_range(0, 12));
				e = s + int'($urandom_range(1, 20));
			end
			default: ;
		endcase
		c.start_row = 16'(s);
		c.end_row = 16'(e);
		send(c);
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 45) : $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(0, 29))
				0, 1, 2: send_write(12'($urandom), texel_pattern());
				3: send_noise();
				default: ;
			endcase
			send_row();
		end
	endtask

	initial begin
		int unsigned w, h, rows;
		int phase_end;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the low part of the texture store; every strip below reads only there.
		for (int a = 0; a < FILL_DEPTH; a++) send_write(12'(a), texel_pattern());

		// Directed transactions at the reset register values.
		idling_on = 1'b1;
		send_row();                                 // row with no strip open
		send_noise();                               // unused function code
		send_begin(10, 10, 5, 7, 1'b0, 1);          // empty strip
		send_row();
		send_begin(32767, -32768, 5, 7, 1'b1, 9);   // reversed rows, empty
		send_begin(478, 490, 31, 2048, 1'b1, 255);  // cut off at the screen bottom
		repeat (2) send_row();
		send_begin(500, 600, 1, 1, 1'b0, 2);        // wholly below the screen
		send_row();
		send_begin(0, 20, 12, 100, 1'b0, 1);
		send_row();
		send_write(12'd204, 32'h0);                 // texel read by the next row
		send_row();
		wait_idle();

		// A short texture keeps the tall strips within the loaded texels.
		program_registers(7'd64, 7'd8, 12'd480);
		send_begin(3, 5, 2, 9, 1'b1, 3);            // replaces the open strip
		repeat (2) send_row();
		send_begin(-32768, 32767, 0, 0, 1'b0, 1);   // extreme rows, far above the screen
		repeat (3) send_row();
		send_begin(-100, 5, 63, 4095, 1'b1, 0);     // zero divisor, last texture column
		repeat (6) send_row();                      // the sixth row finds no strip
		wait_idle();

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin w = 64; h = 8; rows = 2048; end
				1: begin w = 1; h = 1; rows = 1; end
				2: begin w = 0; h = 0; rows = 0; end
				3: begin w = 127; h = 8; rows = 4095; end
				4: begin w = 8; h = 127; rows = 100; end
				default: begin
					w = $urandom_range(1, 64);
					h = $urandom_range(1, (FILL_DEPTH / w > 64) ? 64 : FILL_DEPTH / w);
					rows = $urandom_range(1, 600);
				end
			endcase
			program_registers(7'(w), 7'(h), 12'(rows));
			idling_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) random_strip();
			wait_idle();
		end

		sb.check_drained();
		if (sb.errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
